// File: rtl/sdt_pkg.sv
package sdt_pkg;

    localparam int OPCODE_WIDTH = 2;
    localparam int STATUS_WIDTH = 2;
    localparam int PORT_KEY_WIDTH = 32;
    localparam int POSITION_WIDTH = 4;
    localparam int HELD_WIDTH = 5;

    typedef logic [OPCODE_WIDTH-1:0] opcode_t;
    typedef logic [STATUS_WIDTH-1:0] status_t;

    localparam opcode_t OP_INSERT = 2'd0;
    localparam opcode_t OP_REMOVE = 2'd1;
    localparam opcode_t OP_READ   = 2'd2;

    localparam status_t STATUS_OK        = 2'd0;
    localparam status_t STATUS_FULL      = 2'd1;
    localparam status_t STATUS_NOT_FOUND = 2'd2;
    localparam status_t STATUS_RANGE     = 2'd3;

endpackage

// File: rtl/sdt_ram.sv
module sdt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/sorted_descending_table.sv
// A read fetches the addressed entry, registers it and stages it in the output register;
// an insert or a remove that does not end at once walks the table memory, one entry per
// cycle through its single read and write ports, before its result is staged.
// One operation at a time: the next transfer is taken only once the result of the last
// one is staged in the output register.
// Reset clears the entry count and the handshake state; the table memory is not cleared.
module sorted_descending_table #(
    parameter int CAPACITY  = 16,
    parameter int KEY_WIDTH = 32
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [sdt_pkg::OPCODE_WIDTH-1:0]     s_opcode,
    input  logic [sdt_pkg::PORT_KEY_WIDTH-1:0]   s_key,
    input  logic [sdt_pkg::POSITION_WIDTH-1:0]   s_position,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [sdt_pkg::STATUS_WIDTH-1:0]     m_status,
    output logic [sdt_pkg::PORT_KEY_WIDTH-1:0]   m_read_key,
    output logic [sdt_pkg::HELD_WIDTH-1:0]       m_entries_held
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    // common width for comparing a read position against the count
    localparam int PW = (CW > sdt_pkg::POSITION_WIDTH) ? CW : sdt_pkg::POSITION_WIDTH;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_INS     = 3'd1;
    localparam logic [2:0] ST_INS_TOP = 3'd2;
    localparam logic [2:0] ST_REM     = 3'd3;
    localparam logic [2:0] ST_RD      = 3'd4;
    localparam logic [2:0] ST_DONE    = 3'd5;

    logic [2:0]                           state_reg, state_next;
    logic [CW-1:0]                        cnt_reg, cnt_next;
    logic [CW-1:0]                        idx_reg, idx_next;
    logic [KEY_WIDTH-1:0]                 key_reg, key_next;
    logic                                 found_reg, found_next;
    sdt_pkg::status_t                     res_status_reg, res_status_next;
    logic [sdt_pkg::PORT_KEY_WIDTH-1:0]   res_key_reg, res_key_next;

    logic                                 m_valid_reg, m_valid_next;
    sdt_pkg::status_t                     m_status_reg, m_status_next;
    logic [sdt_pkg::PORT_KEY_WIDTH-1:0]   m_read_key_reg, m_read_key_next;
    logic [sdt_pkg::HELD_WIDTH-1:0]       m_entries_held_reg, m_entries_held_next;

    logic                                 wr_en;
    logic [AW-1:0]                        wr_addr;
    logic [KEY_WIDTH-1:0]                 wr_data;
    logic                                 rd_en;
    logic [AW-1:0]                        rd_addr;
    logic [KEY_WIDTH-1:0]                 rd_data;

    logic [KEY_WIDTH-1:0]                 key_in;
    logic [CW-1:0]                        cnt_last;
    logic [CW-1:0]                        idx_inc;
    logic [CW-1:0]                        idx_dec;
    logic                                 rem_hit;

    // Table storage: entry 0 holds the largest key.
    sdt_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (CAPACITY)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign key_in   = KEY_WIDTH'(s_key);
    assign cnt_last = cnt_reg - 1'b1;
    assign idx_inc  = idx_reg + 1'b1;
    assign idx_dec  = idx_reg - 1'b1;
    assign rem_hit  = found_reg || (rd_data == key_reg);

    // Take a new operation only between operations; a staged result may still wait.
    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next          = state_reg;
        cnt_next            = cnt_reg;
        idx_next            = idx_reg;
        key_next            = key_reg;
        found_next          = found_reg;
        res_status_next     = res_status_reg;
        res_key_next        = res_key_reg;
        m_valid_next        = m_valid_reg && !m_ready;
        m_status_next       = m_status_reg;
        m_read_key_next     = m_read_key_reg;
        m_entries_held_next = m_entries_held_reg;
        wr_en               = 1'b0;
        wr_addr             = '0;
        wr_data             = '0;
        rd_en               = 1'b0;
        rd_addr             = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    key_next        = key_in;
                    res_key_next    = '0;
                    res_status_next = sdt_pkg::STATUS_OK;
                    found_next      = 1'b0;
                    case (s_opcode)
                        sdt_pkg::OP_INSERT: begin
                            if (cnt_reg == CW'(CAPACITY)) begin
                                res_status_next = sdt_pkg::STATUS_FULL;
                                state_next      = ST_DONE;
                            end else if (cnt_reg == '0) begin
                                // empty table: the key lands in the top slot at once
                                wr_en      = 1'b1;
                                wr_addr    = '0;
                                wr_data    = key_in;
                                cnt_next   = cnt_reg + 1'b1;
                                state_next = ST_DONE;
                            end else begin
                                // walk up from the smallest entry
                                rd_en      = 1'b1;
                                rd_addr    = cnt_last[AW-1:0];
                                idx_next   = cnt_last;
                                state_next = ST_INS;
                            end
                        end
                        sdt_pkg::OP_REMOVE: begin
                            if (cnt_reg == '0) begin
                                res_status_next = sdt_pkg::STATUS_NOT_FOUND;
                                state_next      = ST_DONE;
                            end else begin
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                idx_next   = '0;
                                state_next = ST_REM;
                            end
                        end
                        sdt_pkg::OP_READ: begin
                            if (PW'(s_position) >= PW'(cnt_reg)) begin
                                res_status_next = sdt_pkg::STATUS_RANGE;
                                state_next      = ST_DONE;
                            end else begin
                                rd_en      = 1'b1;
                                rd_addr    = AW'(s_position);
                                state_next = ST_RD;
                            end
                        end
                        default: begin
                            // unused opcode: report ok, table untouched
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_INS: begin
                // rd_data is entry idx; entries not greater than the key move down one slot
                wr_en   = 1'b1;
                wr_addr = idx_inc[AW-1:0];
                if (key_reg < rd_data) begin
                    wr_data    = key_reg;
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = ST_DONE;
                end else begin
                    wr_data = rd_data;
                    if (idx_reg == '0) begin
                        state_next = ST_INS_TOP;
                    end else begin
                        rd_en    = 1'b1;
                        rd_addr  = idx_dec[AW-1:0];
                        idx_next = idx_dec;
                    end
                end
            end

            ST_INS_TOP: begin
                wr_en      = 1'b1;
                wr_addr    = '0;
                wr_data    = key_reg;
                cnt_next   = cnt_reg + 1'b1;
                state_next = ST_DONE;
            end

            ST_REM: begin
                // once the match is passed, pull each later entry up one slot
                if (found_reg) begin
                    wr_en   = 1'b1;
                    wr_addr = idx_dec[AW-1:0];
                    wr_data = rd_data;
                end
                found_next = rem_hit;
                if (idx_reg == cnt_last) begin
                    if (rem_hit) begin
                        cnt_next = cnt_reg - 1'b1;
                    end else begin
                        res_status_next = sdt_pkg::STATUS_NOT_FOUND;
                    end
                    state_next = ST_DONE;
                end else begin
                    rd_en    = 1'b1;
                    rd_addr  = idx_inc[AW-1:0];
                    idx_next = idx_inc;
                end
            end

            ST_RD: begin
                res_key_next = sdt_pkg::PORT_KEY_WIDTH'(rd_data);
                state_next   = ST_DONE;
            end

            ST_DONE: begin
                // hold the result until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next        = 1'b1;
                    m_status_next       = res_status_reg;
                    m_read_key_next     = res_key_reg;
                    m_entries_held_next = sdt_pkg::HELD_WIDTH'(cnt_reg);
                    state_next          = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload and scratch registers need no reset
    always_ff @(posedge aclk) begin
        idx_reg            <= idx_next;
        key_reg            <= key_next;
        found_reg          <= found_next;
        res_status_reg     <= res_status_next;
        res_key_reg        <= res_key_next;
        m_status_reg       <= m_status_next;
        m_read_key_reg     <= m_read_key_next;
        m_entries_held_reg <= m_entries_held_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_read_key     = m_read_key_reg;
    assign m_entries_held = m_entries_held_reg;

    // The count never passes the table size.
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(CAPACITY))
        else $error("entry count exceeds capacity");

    // The walk never reads and writes the same entry in one cycle.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("table read and write collide");

    // A rejected insert reports a full table.
    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == sdt_pkg::STATUS_FULL)
            |-> (m_entries_held == sdt_pkg::HELD_WIDTH'(CAPACITY)))
        else $error("full status with table not full");

    // Only a successful operation carries a key.
    a_key_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != sdt_pkg::STATUS_OK) |-> (m_read_key == '0))
        else $error("failed operation returns a key");

endmodule
